@@ rtl/core/weighted_energy_sampler_macros.svh @@
// assertion macros for the weighted energy sampler
// expects clk and rst in the scope of use
`ifndef WEIGHTED_ENERGY_SAMPLER_MACROS_SVH
`define WEIGHTED_ENERGY_SAMPLER_MACROS_SVH

// same-cycle implication
`define WES_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define WES_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/wes_pkg.sv @@
// shared types and constants for the weighted energy sampler
// no dependencies
`timescale 1ns / 1ps

package wes_pkg;

  typedef logic [1:0] op_t;

  localparam op_t OP_CLEAR  = 2'd0;
  localparam op_t OP_LOAD   = 2'd1;
  localparam op_t OP_SAMPLE = 2'd2;

  // full scale of a random word and the rounding offset
  localparam logic [31:0] R_MAX    = 32'hFFFF_FFFF;
  localparam logic [32:0] R_MAX_X2 = 33'h1_FFFF_FFFE;
  localparam logic [63:0] R_HALF   = 64'h0000_0000_8000_0000;

endpackage

@@ rtl/core/wes_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// no dependencies
`timescale 1ns / 1ps

module wes_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/weighted_energy_sampler.sv @@
// weighted energy sampler top level: energy/weight table and inverse-cdf sampling
// depends on wes_pkg, wes_ram and weighted_energy_sampler_macros.svh
//
// usage
//   one request channel: start with op and payload, taken when busy is low
//   clear and load act while idle and may follow back to back; busy stays low
//   a sample on a filled table raises busy until its result is shown; done marks
//   the result for exactly one cycle on energy_out, picked_index and empty_error
//   a sample from an empty table returns its error result in the next cycle
//   a one-entry continuous sample goes straight to the energy reads; any other
//   sample forms its threshold by chunked multiply, then reads the weight ram one
//   entry per cycle through read, accumulate, scale and threshold-test steps,
//   then reads the picked energy entry and, in continuous mode, the next one and
//   interpolates (difference, multiply, split sum, rounding); done follows
//   a scan stops early at the first matching entry
//   reset empties the table; ram contents stay as they were and are never used
//   past the entry count
//   results cannot be held off by the receiver
`timescale 1ns / 1ps
`include "weighted_energy_sampler_macros.svh"

module weighted_energy_sampler #(
  parameter int MAX_ENTRIES = 1024,
  parameter int VALUE_BITS  = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  wes_pkg::op_t  op,
  input  logic [31:0]   entry_energy,
  input  logic [31:0]   entry_weight,
  input  logic [31:0]   rand_a,
  input  logic [31:0]   rand_b,
  input  logic          continuous,
  output logic          busy,
  output logic          done,
  output logic [31:0]   energy_out,
  output logic [9:0]    picked_index,
  output logic          empty_error
);

  import wes_pkg::*;

  localparam int SW  = (VALUE_BITS < 32) ? VALUE_BITS : 32;
  localparam int AW  = $clog2(MAX_ENTRIES);
  localparam int CW  = $clog2(MAX_ENTRIES + 1);
  localparam int TW  = SW + AW;
  localparam int AC  = TW + 1;
  localparam int LW  = AC + 32;
  localparam int NCH = (AC + 31) / 32;
  localparam int TGW = NCH * 32 + 32;
  localparam int CHW = $clog2(NCH + 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_MUL  = 4'd1;
  localparam logic [3:0] S_SCAN = 4'd2;
  localparam logic [3:0] S_E0   = 4'd3;
  localparam logic [3:0] S_E1   = 4'd4;
  localparam logic [3:0] S_E2   = 4'd5;
  localparam logic [3:0] S_MP   = 4'd6;
  localparam logic [3:0] S_QS   = 4'd7;
  localparam logic [3:0] S_QR   = 4'd8;
  localparam logic [3:0] S_F    = 4'd9;

  logic [3:0]        state;
  logic [CW-1:0]     count;
  logic [TW-1:0]     total;
  logic [SW-1:0]     w_first;
  logic [SW-1:0]     w_last;

  logic              cont_r;
  logic              interp;
  logic [31:0]       ra_r;
  logic [31:0]       rb_r;
  logic [AW-1:0]     last_cand;

  logic [AC-1:0]     scale;
  logic [CHW-1:0]    chunk;
  logic [CHW-1:0]    mul_k;
  logic              mul_v;
  logic [63:0]       mul_prod;
  logic [TGW-1:0]    target;

  logic [AW-1:0]     rd_idx;
  logic              rd_on;
  logic              p1_valid;
  logic [AW-1:0]     p1_idx;
  logic [SW-1:0]     prev_w;
  logic              have_prev;
  logic [AC-1:0]     acc;
  logic              p2_valid;
  logic [AW-1:0]     p2_idx;
  logic [LW-1:0]     lhs;
  logic              p3_valid;
  logic [AW-1:0]     p3_idx;

  logic [AW-1:0]     sel_idx;
  logic [SW-1:0]     e0;
  logic [SW-1:0]     diff;
  logic              neg;
  logic [SW+31:0]    mprod;
  logic [31:0]       q_h;
  logic [32:0]       q_s;
  logic [31:0]       q;

  logic              accept;
  logic              wr_en;
  logic [SW-1:0]     w_rdata;
  logic [SW-1:0]     e_rdata;
  logic [AW-1:0]     e_raddr;
  logic [NCH*32-1:0] scale_pad;
  logic              hit;
  logic [63:0]       qx;
  logic [AC-1:0]     red2;
  logic [SW-1:0]     e_final;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign wr_en     = accept && (op == OP_LOAD) && (count < CW'(MAX_ENTRIES));
  assign scale_pad = (NCH * 32)'(scale);
  assign hit       = (TGW'(lhs) >= target);
  assign e_raddr   = (state == S_E1) ? sel_idx + AW'(1) : sel_idx;
  assign qx        = 64'(mprod) + R_HALF;
  assign red2      = {total, 1'b0} - AC'(w_first) - AC'(w_last);
  assign e_final   = neg ? e0 - SW'(q) : e0 + SW'(q);

  wes_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_weight_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (entry_weight[SW-1:0]),
    .raddr (rd_idx),
    .rdata (w_rdata)
  );

  wes_ram #(.WIDTH(SW), .DEPTH(MAX_ENTRIES)) u_energy_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (count[AW-1:0]),
    .wdata (entry_energy[SW-1:0]),
    .raddr (e_raddr),
    .rdata (e_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      total    <= '0;
      done     <= 1'b0;
      mul_v    <= 1'b0;
      rd_on    <= 1'b0;
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      p3_valid <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (op)
              OP_CLEAR: begin
                count <= '0;
                total <= '0;
              end
              OP_LOAD: begin
                if (count < CW'(MAX_ENTRIES)) begin
                  count  <= count + CW'(1);
                  total  <= total + TW'(entry_weight[SW-1:0]);
                  w_last <= entry_weight[SW-1:0];
                  if (count == '0) begin
                    w_first <= entry_weight[SW-1:0];
                  end
                end
              end
              OP_SAMPLE: begin
                if (count == '0) begin
                  done         <= 1'b1;
                  energy_out   <= '0;
                  picked_index <= '0;
                  empty_error  <= 1'b1;
                end else if (continuous && count == CW'(1)) begin
                  sel_idx <= '0;
                  interp  <= 1'b0;
                  state   <= S_E0;
                end else begin
                  scale     <= continuous ? red2 : AC'(total);
                  interp    <= continuous;
                  cont_r    <= continuous;
                  ra_r      <= rand_a;
                  rb_r      <= rand_b;
                  last_cand <= continuous ? AW'(count - CW'(2)) : AW'(count - CW'(1));
                  chunk     <= '0;
                  mul_v     <= 1'b0;
                  target    <= '0;
                  state     <= S_MUL;
                end
              end
              default: ;
            endcase
          end
        end
        S_MUL: begin
          if (chunk < CHW'(NCH)) begin
            mul_prod <= ra_r * scale_pad[chunk*32 +: 32];
            mul_k    <= chunk;
            chunk    <= chunk + CHW'(1);
            mul_v    <= 1'b1;
          end else begin
            mul_v <= 1'b0;
          end
          if (mul_v) begin
            target <= target + (TGW'(mul_prod) << (32 * mul_k));
          end
          if (chunk == CHW'(NCH)) begin
            state     <= S_SCAN;
            rd_idx    <= '0;
            rd_on     <= 1'b1;
            p1_valid  <= 1'b0;
            p2_valid  <= 1'b0;
            p3_valid  <= 1'b0;
            acc       <= '0;
            have_prev <= 1'b0;
          end
        end
        S_SCAN: begin
          // read issue
          p1_valid <= rd_on;
          p1_idx   <= rd_idx;
          if (rd_on) begin
            if (rd_idx == AW'(count - CW'(1))) begin
              rd_on <= 1'b0;
            end else begin
              rd_idx <= rd_idx + AW'(1);
            end
          end
          // accumulate
          p2_valid <= 1'b0;
          if (p1_valid) begin
            prev_w <= w_rdata;
            if (cont_r) begin
              have_prev <= 1'b1;
              if (have_prev) begin
                acc      <= acc + AC'(prev_w) + AC'(w_rdata);
                p2_valid <= 1'b1;
                p2_idx   <= p1_idx - AW'(1);
              end
            end else begin
              acc      <= acc + AC'(w_rdata);
              p2_valid <= 1'b1;
              p2_idx   <= p1_idx;
            end
          end
          // scale by full random range
          p3_valid <= p2_valid;
          p3_idx   <= p2_idx;
          lhs      <= {acc, 32'b0} - LW'(acc);
          // threshold test
          if (p3_valid && (hit || p3_idx == last_cand)) begin
            sel_idx  <= p3_idx;
            rd_on    <= 1'b0;
            p1_valid <= 1'b0;
            p2_valid <= 1'b0;
            p3_valid <= 1'b0;
            state    <= S_E0;
          end
        end
        S_E0: begin
          state <= S_E1;
        end
        S_E1: begin
          e0 <= e_rdata;
          if (interp) begin
            state <= S_E2;
          end else begin
            done         <= 1'b1;
            energy_out   <= 32'(e_rdata);
            picked_index <= 10'(sel_idx);
            empty_error  <= 1'b0;
            state        <= S_IDLE;
          end
        end
        S_E2: begin
          neg   <= (e_rdata < e0);
          diff  <= (e_rdata < e0) ? e0 - e_rdata : e_rdata - e0;
          state <= S_MP;
        end
        S_MP: begin
          mprod <= diff * rb_r;
          state <= S_QS;
        end
        S_QS: begin
          q_h   <= qx[63:32];
          q_s   <= {1'b0, qx[63:32]} + {1'b0, qx[31:0]};
          state <= S_QR;
        end
        S_QR: begin
          if (q_s >= R_MAX_X2) begin
            q <= q_h + 32'd2;
          end else if (q_s >= {1'b0, R_MAX}) begin
            q <= q_h + 32'd1;
          end else begin
            q <= q_h;
          end
          state <= S_F;
        end
        S_F: begin
          done         <= 1'b1;
          energy_out   <= 32'(e_final);
          picked_index <= 10'(sel_idx);
          empty_error  <= 1'b0;
          state        <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  `WES_ASSERT_NEXT(a_empty_result, accept && op == OP_SAMPLE && count == '0,
    done && empty_error, "empty sample did not give an error result")
  `WES_ASSERT(a_total_clear, count == '0, total == '0,
    "weight total not zero for an empty table")
  `WES_ASSERT(a_sel_in_table, state == S_E0 || state == S_E1, CW'(sel_idx) < count,
    "selected entry beyond the table")
  `WES_ASSERT(a_done_idle, done, state == S_IDLE,
    "result shown while a sample is still running")

endmodule

@@ tb/weighted_energy_sampler_test.sv @@
// testbench for weighted_energy_sampler: directed table then random clear/load/sample sequences
// depends on wes_pkg and the weighted_energy_sampler rtl; draws are checked against a model or the plan
`timescale 1ns / 1ps

module weighted_energy_sampler_test;
  import wes_pkg::*;

  localparam int TABLE_DEPTH = 1024;
  localparam int RANDOM_REQUESTS = 540;
  localparam int SETTLE_CYCLES = 1100;
  localparam op_t OP_NONE = 2'd3;
  localparam logic [31:0] ALL1 = 32'hFFFF_FFFF;
  localparam logic [31:0] HALF = 32'h8000_0000;

  typedef struct packed {
    op_t         op;
    logic [31:0] energy;
    logic [31:0] weight;
    logic [31:0] ra;
    logic [31:0] rb;
    logic        cont;
  } request_t;

  typedef struct packed {
    logic [31:0] energy;
    logic [9:0]  index;
    logic        err;
  } draw_t;

  typedef struct packed {
    request_t req;
    logic     fixed;
    draw_t    draw;
  } plan_row_t;

  localparam int PLAN_ROWS = 24;

  logic clk = 1'b0;
  logic rst;
  logic start;
  op_t op;
  logic [31:0] entry_energy;
  logic [31:0] entry_weight;
  logic [31:0] rand_a;
  logic [31:0] rand_b;
  logic continuous;
  logic busy;
  logic done;
  logic [31:0] energy_out;
  logic [9:0] picked_index;
  logic empty_error;

  weighted_energy_sampler dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .op(op),
    .entry_energy(entry_energy),
    .entry_weight(entry_weight),
    .rand_a(rand_a),
    .rand_b(rand_b),
    .continuous(continuous),
    .busy(busy),
    .done(done),
    .energy_out(energy_out),
    .picked_index(picked_index),
    .empty_error(empty_error)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // local copy of the table
  logic [31:0] tbl_energy [TABLE_DEPTH];
  logic [31:0] tbl_weight [TABLE_DEPTH];
  int unsigned tbl_count;
  logic [63:0] tbl_total;

  draw_t pending_draws [$];
  int errors = 0;
  int draws_checked = 0;
  int n_samples = 0;
  int n_loads = 0;
  int n_dropped = 0;
  int n_ignored = 0;
  int idle_pct = 0;

  plan_row_t plan [PLAN_ROWS] = '{
    '{'{OP_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1, '{32'h0, 10'd0, 1'b1}},
    '{'{OP_SAMPLE, ALL1, ALL1, ALL1, ALL1, 1'b1}, 1'b1, '{32'h0, 10'd0, 1'b1}},
    '{'{OP_NONE, ALL1, ALL1, ALL1, ALL1, 1'b1}, 1'b0, '0},
    '{'{OP_LOAD, 32'h0001_0000, 32'h1, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{'{OP_SAMPLE, 32'h0, 32'h0, 32'h0, ALL1, 1'b1}, 1'b1, '{32'h0001_0000, 10'd0, 1'b0}},
    '{'{OP_SAMPLE, 32'h0, 32'h0, ALL1, 32'h0, 1'b0}, 1'b1, '{32'h0001_0000, 10'd0, 1'b0}},
    '{'{OP_LOAD, ALL1, ALL1, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{'{OP_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1, '{32'h0001_0000, 10'd0, 1'b0}},
    '{'{OP_SAMPLE, 32'h0, 32'h0, ALL1, 32'h0, 1'b0}, 1'b1, '{ALL1, 10'd1, 1'b0}},
    '{'{OP_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1}, 1'b1, '{32'h0001_0000, 10'd0, 1'b0}},
    '{'{OP_SAMPLE, 32'h0, 32'h0, ALL1, ALL1, 1'b1}, 1'b1, '{ALL1, 10'd0, 1'b0}},
    '{'{OP_SAMPLE, 32'h0, 32'h0, HALF, HALF, 1'b1}, 1'b0, '0},
    '{'{OP_CLEAR, ALL1, ALL1, ALL1, ALL1, 1'b1}, 1'b0, '0},
    '{'{OP_SAMPLE, 32'h0, 32'h0, HALF, 32'h0, 1'b0}, 1'b1, '{32'h0, 10'd0, 1'b1}},
    '{'{OP_LOAD, ALL1, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{'{OP_LOAD, 32'h0, ALL1, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{'{OP_SAMPLE, 32'h0, 32'h0, 32'h1234, ALL1, 1'b1}, 1'b1, '{32'h0, 10'd0, 1'b0}},
    '{'{OP_SAMPLE, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0}, 1'b1, '{ALL1, 10'd0, 1'b0}},
    '{'{OP_SAMPLE, 32'h0, 32'h0, ALL1, 32'h0, 1'b0}, 1'b1, '{32'h0, 10'd1, 1'b0}},
    '{'{OP_SAMPLE, 32'h0, 32'h0, 32'h77, HALF, 1'b1}, 1'b0, '0},
    '{'{OP_LOAD, 32'h1234_5678, 32'h8000, 32'h0, 32'h0, 1'b0}, 1'b0, '0},
    '{'{OP_SAMPLE, 32'h0, 32'h0, HALF, 32'h4000_0000, 1'b1}, 1'b0, '0},
    '{'{OP_SAMPLE, 32'h0, 32'h0, ALL1, 32'h1, 1'b1}, 1'b0, '0},
    '{'{OP_SAMPLE, 32'h0, 32'h0, 32'hC000_0000, 32'h0, 1'b0}, 1'b0, '0}
  };

  // acc / scale has reached r / full scale, compared exactly
  function automatic bit crossed(logic [63:0] acc, logic [31:0] r, logic [63:0] scale);
    logic [127:0] lhs;
    logic [127:0] rhs;
    lhs = 128'(acc) * 128'(R_MAX);
    rhs = 128'(scale) * 128'(r);
    return lhs >= rhs;
  endfunction

  function automatic logic [31:0] lerp(logic [31:0] e0, logic [31:0] e1, logic [31:0] frac);
    logic [127:0] d;
    logic [127:0] q;
    d = (e1 >= e0) ? 128'(e1) - 128'(e0) : 128'(e0) - 128'(e1);
    q = (d * 128'(frac) + 128'(HALF)) / 128'(R_MAX);
    return (e1 >= e0) ? e0 + q[31:0] : e0 - q[31:0];
  endfunction

  function automatic draw_t draw_energy(logic [31:0] ra, logic [31:0] rb, logic cont);
    draw_t d;
    logic [63:0] acc;
    logic [63:0] red2;
    int k;
    int pick;
    d = '0;
    acc = '0;
    if (tbl_count == 0) begin
      d.err = 1'b1;
      return d;
    end
    if (cont) begin
      if (tbl_count == 1) begin
        pick = 0;
        d.energy = tbl_energy[0];
      end else begin
        red2 = 2 * tbl_total - 64'(tbl_weight[0]) - 64'(tbl_weight[tbl_count - 1]);
        pick = tbl_count - 2;
        for (k = 0; k < int'(tbl_count) - 2; k++) begin
          acc += 64'(tbl_weight[k]) + 64'(tbl_weight[k + 1]);
          if (crossed(acc, ra, red2)) begin
            pick = k;
            break;
          end
        end
        d.energy = lerp(tbl_energy[pick], tbl_energy[pick + 1], rb);
      end
    end else begin
      pick = tbl_count - 1;
      for (k = 0; k < int'(tbl_count); k++) begin
        acc += 64'(tbl_weight[k]);
        if (crossed(acc, ra, tbl_total)) begin
          pick = k;
          break;
        end
      end
      d.energy = tbl_energy[pick];
    end
    d.index = pick[9:0];
    return d;
  endfunction

  // updates the table for one request; returns 0 when the block drops or ignores it
  function automatic bit apply_request(request_t r, output bit gives, output draw_t d);
    gives = 1'b0;
    d = '0;
    case (r.op)
      OP_CLEAR: begin
        tbl_count = 0;
        tbl_total = '0;
        return 1'b1;
      end
      OP_LOAD: begin
        if (tbl_count >= TABLE_DEPTH) begin
          n_dropped++;
          return 1'b0;
        end
        tbl_energy[tbl_count] = r.energy;
        tbl_weight[tbl_count] = r.weight;
        tbl_total += 64'(r.weight);
        tbl_count++;
        n_loads++;
        return 1'b1;
      end
      OP_SAMPLE: begin
        gives = 1'b1;
        d = draw_energy(r.ra, r.rb, r.cont);
        n_samples++;
        return 1'b1;
      end
      default: begin
        n_ignored++;
        return 1'b0;
      end
    endcase
  endfunction

  // drives one request and waits until it is taken
  task automatic issue(input request_t r, input bit fixed, input draw_t fixed_draw,
                       output bit took_effect);
    bit gives;
    draw_t d;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    op <= r.op;
    entry_energy <= r.energy;
    entry_weight <= r.weight;
    rand_a <= r.ra;
    rand_b <= r.rb;
    continuous <= r.cont;
    do @(posedge clk); while (busy);
    took_effect = apply_request(r, gives, d);
    if (gives) pending_draws = {pending_draws, (fixed ? fixed_draw : d)};
  endtask

  function automatic logic [31:0] pick_weight();
    case ($urandom_range(9))
      0: return 32'h0;
      1, 2, 3: return 32'($urandom_range(15));
      4, 5: return 32'($urandom_range(65535));
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_position();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return ALL1;
      default: return $urandom;
    endcase
  endfunction

  function automatic request_t random_request(op_t kind);
    request_t r;
    r.op = kind;
    r.energy = $urandom;
    r.weight = pick_weight();
    r.ra = pick_position();
    r.rb = pick_position();
    r.cont = 1'($urandom_range(1));
    return r;
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (pending_draws.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    draw_t x;
    if (!rst && done) begin
      if (pending_draws.size() == 0) begin
        $error("unexpected result: energy_out %h picked_index %0d empty_error %b",
               energy_out, picked_index, empty_error);
        errors++;
      end else begin
        x = pending_draws.pop_front();
        draws_checked++;
        if (energy_out !== x.energy) begin
          $error("energy_out: expected %h, got %h", x.energy, energy_out);
          errors++;
        end
        if (picked_index !== x.index) begin
          $error("picked_index: expected %0d, got %0d", x.index, picked_index);
          errors++;
        end
        if (empty_error !== x.err) begin
          $error("empty_error: expected %b, got %b", x.err, empty_error);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    int seq;
    int rand_done;
    int n;
    int k;
    bit took;
    rst = 1'b1;
    start = 1'b0;
    op = OP_CLEAR;
    entry_energy = '0;
    entry_weight = '0;
    rand_a = '0;
    rand_b = '0;
    continuous = 1'b0;
    tbl_count = 0;
    tbl_total = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) issue(plan[i].req, plan[i].fixed, plan[i].draw, took);
    drain();

    seq = 0;
    rand_done = 0;
    while (rand_done < RANDOM_REQUESTS) begin
      case ((seq / 4) % 3)
        0: idle_pct = 0;
        1: idle_pct = 86;
        default: idle_pct = 12;
      endcase
      if (seq % 6 == 5) drain();
      if ($urandom_range(3) != 0) begin
        issue(random_request(OP_CLEAR), 1'b0, '0, took);
        rand_done += int'(took);
      end
      n = ($urandom_range(9) == 0) ? $urandom_range(64, 9) : $urandom_range(8);
      for (k = 0; k < n; k++) begin
        issue(random_request(OP_LOAD), 1'b0, '0, took);
        rand_done += int'(took);
      end
      n = $urandom_range(6, 1);
      for (k = 0; k < n; k++) begin
        if ($urandom_range(11) == 0) issue(random_request(OP_NONE), 1'b0, '0, took);
        issue(random_request(OP_SAMPLE), 1'b0, '0, took);
        rand_done += int'(took);
      end
      seq++;
    end
    start <= 1'b0;

    while (pending_draws.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("covered %0d loads (%0d dropped on a full table), %0d samples, %0d unknown ops",
             n_loads, n_dropped, n_samples, n_ignored);
    $display("%0d draws checked across %0d random sequences and idle phases", draws_checked, seq);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ weighted_energy_sampler.f @@
+incdir+rtl/core
rtl/core/wes_pkg.sv
rtl/core/wes_ram.sv
rtl/core/weighted_energy_sampler.sv
tb/weighted_energy_sampler_test.sv
